### rtl/core/bm3_pkg.sv
// shared types and constants for the 3x3 binary morphology block
package bm3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int PIXEL_W        = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int OUT_COL_W      = 10;
   localparam int OUT_ROW_W      = 12;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MORPH_MODE   = 2'd2;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam logic MORPH_ERODE  = 1'b0;
   localparam logic MORPH_DILATE = 1'b1;

   localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

   localparam int WINDOW_BITS = 9;

   // result queue depth, enough to keep one request per cycle flowing
   localparam int OUTQ_DEPTH = 3;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   pixel_out;
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 frame_last;
   } rsp_payload_type;

endpackage

### rtl/core/bm3_line_mem.sv
// two-bit wide line store memory, one write and one registered read port
module bm3_line_mem #(
   parameter int DEPTH = bm3_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW    = $clog2(bm3_pkg::MAX_WIDTH_DEFAULT)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_data
);

   // bit 1 middle row, bit 0 upper row
   logic [1:0] mem_ff [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bm3_out_queue.sv
// small register queue holding finished results for the response channel
module bm3_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bm3_pkg::rsp_payload_type push_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bm3_pkg::rsp_payload_type rsp_data,
   output logic [$clog2(bm3_pkg::OUTQ_DEPTH+1)-1:0] level
);

   localparam int DEPTH = bm3_pkg::OUTQ_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);

   bm3_pkg::rsp_payload_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;
   logic          pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/binary_morphology_3x3.sv
// top level of the 3x3 binary erosion / dilation block
//
// Pixels arrive in raster order on the req_ channel, one request per cycle at
// full rate; a nonzero pixel_value counts as on, frame_start forces column 0,
// row 0. For every interior pixel one result leaves on the rsp_ channel with
// 255 or 0 and its column and row; border pixels give no result.
// The csr_ channel writes frame_width, frame_height and morph_mode (0 erode,
// 1 dilate); csr_ready is always high and writes belong in idle periods.
// An accepted request reads the line store memory into its registered read
// port; stage one then updates the window and the result enters a three-entry
// queue that drives rsp_valid. While the receiver keeps up, throughput is one
// pixel per cycle, set by the single line store read-modify-write per pixel.
// When the receiver stalls, results collect in the queue and req_ready drops
// once the queue and the pixel in flight would fill it; nothing is lost.
// After reset a pass clears all MAX_WIDTH entries of the line store, during
// which req_ready stays low; registers return to 640 x 480, erosion.
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bm3_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bm3_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bm3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bm3_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int LW  = (CW + 1 > bm3_pkg::FRAME_WIDTH_W) ? CW + 1 : bm3_pkg::FRAME_WIDTH_W;
   localparam int HW  = bm3_pkg::FRAME_HEIGHT_W;
   localparam int QLW = $clog2(bm3_pkg::OUTQ_DEPTH + 1);
   localparam int WB  = bm3_pkg::WINDOW_BITS;

   // configuration registers
   logic [bm3_pkg::FRAME_WIDTH_W-1:0] frame_width_ff;
   logic [HW-1:0]                     frame_height_ff;
   logic                              morph_mode_ff;

   // clearing pass
   logic          clr_ff, clr_in;
   logic [CW-1:0] clr_idx_ff, clr_idx_in;

   // position
   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;

   // stage one: read data returns, window and write-back
   logic                          s1_valid_ff;
   logic                          s1_bit_ff;
   logic                          s1_emit_ff;
   logic                          s1_last_ff;
   logic [bm3_pkg::OUT_COL_W-1:0] s1_col_ff;
   logic [bm3_pkg::OUT_ROW_W-1:0] s1_row_ff;
   logic [CW-1:0]                 s1_idx_ff;
   logic                          fwd_ff;
   logic [1:0]                    fwd_data_ff;
   logic [WB-1:0]                 win_ff, win_in;

   logic          req_accept;
   logic [CW-1:0] col_cur;
   logic [HW-1:0] row_cur;
   logic [LW-1:0] fw_ext, used_w, col_ext, col_inc, col_dec;
   logic [HW-1:0] used_h;
   logic [HW:0]   row_inc, h_ext;
   logic          emit_cur, last_cur;

   logic          mem_wr_en;
   logic [CW-1:0] mem_wr_addr;
   logic [1:0]    mem_wr_data;
   logic [1:0]    mem_rd_data;
   logic [1:0]    stored;
   logic          win_on;

   bm3_pkg::rsp_payload_type push_data;
   logic                     push;
   logic [QLW-1:0]           q_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bm3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bm3_pkg::FRAME_HEIGHT_RESET;
         morph_mode_ff   <= bm3_pkg::MORPH_ERODE;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == bm3_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_data[bm3_pkg::FRAME_WIDTH_W-1:0];
         end else if (csr_index == bm3_pkg::CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data[HW-1:0];
         end else if (csr_index == bm3_pkg::CSR_MORPH_MODE) begin
            morph_mode_ff <= csr_data[0];
         end
      end
   end

   // keep room in the queue for the pixel in flight and this one
   assign req_ready  = !clr_ff &&
                       ((QLW + 1)'(q_level) + (QLW + 1)'(s1_valid_ff) <
                        (QLW + 1)'(bm3_pkg::OUTQ_DEPTH));
   assign req_accept = req_valid && req_ready;

   // used frame size
   always_comb begin
      fw_ext = LW'(frame_width_ff);
      if (fw_ext < LW'(3)) begin
         used_w = LW'(3);
      end else if (fw_ext > LW'(MAX_WIDTH)) begin
         used_w = LW'(MAX_WIDTH);
      end else begin
         used_w = fw_ext;
      end
      used_h = (frame_height_ff < HW'(3)) ? HW'(3) : frame_height_ff;
      h_ext  = {1'b0, used_h};
   end

   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      col_ext  = LW'(col_cur);
      col_inc  = col_ext + 1'b1;
      col_dec  = col_ext - 1'b1;
      row_inc  = {1'b0, row_cur} + 1'b1;
      emit_cur = (col_ext >= LW'(2)) && (row_cur >= HW'(2)) &&
                 (col_ext < used_w) && (row_cur < used_h);
      last_cur = (col_inc == used_w) && (row_inc == h_ext);
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_accept) begin
         if (col_inc >= used_w) begin
            col_in = '0;
            row_in = (row_inc >= h_ext) ? '0 : row_inc[HW-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CW'(MAX_WIDTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_idx_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_idx_ff  <= clr_idx_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= req_accept;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_bit_ff   <= (req_data.pixel_value != '0);
         s1_emit_ff  <= emit_cur;
         s1_last_ff  <= last_cur;
         s1_col_ff   <= col_dec[bm3_pkg::OUT_COL_W-1:0];
         s1_row_ff   <= row_cur - 1'b1;
         s1_idx_ff   <= col_cur;
         // same entry written this cycle: the memory read returns stale data
         fwd_ff      <= mem_wr_en && (mem_wr_addr == col_cur);
         fwd_data_ff <= mem_wr_data;
      end
   end

   assign stored = fwd_ff ? fwd_data_ff : mem_rd_data;

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         // newest column: upper, middle, current from low to high
         win_in = {s1_bit_ff, stored[1], stored[0], win_ff[WB-1:3]};
      end
      win_on = (morph_mode_ff == bm3_pkg::MORPH_DILATE) ? (win_in != '0) : (&win_in);
   end

   assign mem_wr_en   = clr_ff || s1_valid_ff;
   assign mem_wr_addr = clr_ff ? clr_idx_ff : s1_idx_ff;
   assign mem_wr_data = clr_ff ? 2'b00 : {s1_bit_ff, stored[1]};

   bm3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (mem_rd_data)
   );

   assign push = s1_valid_ff && s1_emit_ff;

   always_comb begin
      push_data.pixel_out  = win_on ? bm3_pkg::PIXEL_ON : bm3_pkg::PIXEL_OFF;
      push_data.out_col    = s1_col_ff;
      push_data.out_row    = s1_row_ff;
      push_data.frame_last = s1_last_ff;
   end

   bm3_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (q_level)
   );

endmodule
